// ===== design/hfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types and constants of the HDLC frame deframer.
// ----------------------------------------------------------------------------
package hfd_pkg;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  localparam int unsigned RawSat      = 6;
  localparam int unsigned RawCntW     = 3;
  localparam int unsigned UnsCntW     = 17;
  localparam int unsigned HeaderBytes = 4;

  // result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [1:0] {
    StComplete      = 2'd0,
    StPayloadShort  = 2'd1,
    StRawShort      = 2'd2,
    StHeaderIncompl = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pl_byte;
    logic [15:0] pl_index;
    logic [15:0] ftype;
    logic [15:0] plen;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;     // results produced by this transaction: 0, 1 or 2
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ===== design/hfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_core
// Unstuffing, header capture and result generation for one raw byte.
// ----------------------------------------------------------------------------
module hfd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [7:0]      raw_byte_i,
  input  logic            last_i,
  output hfd_pkg::push_t  push_o
);

  logic                        esc_q, esc_d;
  logic [hfd_pkg::RawCntW-1:0] raw_q, raw_d, raw_inc;
  logic [hfd_pkg::UnsCntW-1:0] uns_q, uns_d, uns_inc, pay_pos;
  logic [15:0]                 type_q, type_d, type_upd;
  logic [15:0]                 len_q, len_d, len_upd;
  logic                        have_data, emit;
  logic [7:0]                  data;
  hfd_pkg::result_t            pay_res, st_res;

  always_comb begin
    raw_inc = (raw_q < hfd_pkg::RawCntW'(hfd_pkg::RawSat)) ? raw_q + 1'b1 : raw_q;

    have_data = (raw_byte_i != hfd_pkg::FlagByte) && (raw_byte_i != hfd_pkg::EscByte);
    data      = esc_q ? (raw_byte_i ^ hfd_pkg::EscXor) : raw_byte_i;

    if (raw_byte_i == hfd_pkg::FlagByte) begin
      esc_d = esc_q;
    end else if (raw_byte_i == hfd_pkg::EscByte) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
    end

    type_upd = type_q;
    len_upd  = len_q;
    emit     = 1'b0;
    pay_pos  = uns_q - hfd_pkg::UnsCntW'(hfd_pkg::HeaderBytes);
    if (have_data) begin
      if (uns_q < hfd_pkg::UnsCntW'(2)) begin
        type_upd = {type_q[7:0], data};
      end else if (uns_q < hfd_pkg::UnsCntW'(hfd_pkg::HeaderBytes)) begin
        len_upd = {len_q[7:0], data};
      end else if (pay_pos < {1'b0, len_q}) begin
        emit = 1'b1;
      end
    end
    uns_inc = (have_data && (uns_q != '1)) ? uns_q + 1'b1 : uns_q;

    pay_res          = '0;
    pay_res.kind     = hfd_pkg::KindPayload;
    pay_res.pl_byte  = data;
    pay_res.pl_index = pay_pos[15:0];
    pay_res.status   = hfd_pkg::StComplete;

    st_res      = '0;
    st_res.kind = hfd_pkg::KindStatus;
    st_res.last = 1'b1;
    if (raw_inc < hfd_pkg::RawCntW'(hfd_pkg::RawSat)) begin
      st_res.status = hfd_pkg::StRawShort;
    end else if (uns_inc < hfd_pkg::UnsCntW'(hfd_pkg::HeaderBytes)) begin
      st_res.status = hfd_pkg::StHeaderIncompl;
    end else begin
      st_res.ftype  = type_upd;
      st_res.plen   = len_upd;
      st_res.status = ((uns_inc - hfd_pkg::UnsCntW'(hfd_pkg::HeaderBytes)) >= {1'b0, len_upd})
                      ? hfd_pkg::StComplete : hfd_pkg::StPayloadShort;
    end

    // payload byte goes first when both occur
    push_o = '0;
    if (adv_i) begin
      if (emit && last_i) begin
        push_o.n    = 2'd2;
        push_o.res0 = pay_res;
        push_o.res1 = st_res;
      end else if (emit) begin
        push_o.n    = 2'd1;
        push_o.res0 = pay_res;
      end else if (last_i) begin
        push_o.n    = 2'd1;
        push_o.res0 = st_res;
      end
    end

    if (last_i) begin
      esc_d  = 1'b0;
      raw_d  = '0;
      uns_d  = '0;
      type_d = '0;
      len_d  = '0;
    end else begin
      raw_d  = raw_inc;
      uns_d  = uns_inc;
      type_d = type_upd;
      len_d  = len_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      raw_q  <= '0;
      uns_q  <= '0;
      type_q <= '0;
      len_q  <= '0;
    end else if (adv_i) begin
      esc_q  <= esc_d;
      raw_q  <= raw_d;
      uns_q  <= uns_d;
      type_q <= type_d;
      len_q  <= len_d;
    end
  end

endmodule

// ===== design/hfd_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_result_fifo
// Small result queue: up to two in per cycle, one out per cycle on out_ready_i.
// ----------------------------------------------------------------------------
module hfd_result_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hfd_pkg::push_t                    push_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hfd_pkg::result_t                  out_res_o,
  output logic [hfd_pkg::QueueCntW-1:0]     count_o
);

  hfd_pkg::result_t                   mem_q [hfd_pkg::QueueDepth];
  logic [hfd_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [hfd_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                               pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign count_o     = count_q;
  assign wr_ptr1     = wr_ptr_q + 1'b1;
  assign count_d     = count_q + hfd_pkg::QueueCntW'(push_i.n)
                       - hfd_pkg::QueueCntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < hfd_pkg::QueueDepth; i++) begin
      if ((push_i.n != 2'd0) && (wr_ptr_q == hfd_pkg::QueuePtrW'(i))) begin
        mem_q[i] <= push_i.res0;
      end else if ((push_i.n == 2'd2) && (wr_ptr1 == hfd_pkg::QueuePtrW'(i))) begin
        mem_q[i] <= push_i.res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + hfd_pkg::QueuePtrW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + hfd_pkg::QueuePtrW'(pop);
      count_q  <= count_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q + hfd_pkg::QueueCntW'(push_i.n)) <= hfd_pkg::QueueCntW'(hfd_pkg::QueueDepth)
                                                 + hfd_pkg::QueueCntW'(pop))
    else $error("result queue overflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hfd_pkg::QueueCntW'(hfd_pkg::QueueDepth))
    else $error("result queue count out of range");

endmodule

// ===== design/hdlc_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_frame_deframer
// HDLC byte unstuffing with header parse and indexed payload extraction.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+------------------------------
// in      | sink      | in_valid_i / in_ready_o | raw_byte_i, last_of_buffer_i
// out     | source    | out_valid_o/out_ready_i | result_kind_o .. last_o
//
// One raw byte per clock is taken while the input register can advance.
// A transaction is held in the input register, then the core turns it into
// zero, one or two results written to a four-entry queue; results leave one
// per clock while out_ready_i is high. The input register only advances when
// the queue has room for two results, so a stalled output back-pressures the
// input within a few transactions. Asynchronous active-low reset clears the
// deframer state, queue and input register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hdlc_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_byte_i,
  input  logic        last_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [15:0] frame_type_o,
  output logic [15:0] payload_length_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  logic                           adv;
  hfd_pkg::push_t                 push;
  hfd_pkg::result_t               out_res;
  logic [hfd_pkg::QueueCntW-1:0]  q_count;

  // room for two more results, counting none leaving this cycle
  assign adv        = s1_valid_q
                      && (q_count <= hfd_pkg::QueueCntW'(hfd_pkg::QueueDepth - 2));
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= raw_byte_i;
      s1_last_q <= last_of_buffer_i;
    end
  end

  hfd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .raw_byte_i (s1_byte_q),
    .last_i     (s1_last_q),
    .push_o     (push)
  );

  hfd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res),
    .count_o     (q_count)
  );

  assign result_kind_o    = out_res.kind;
  assign payload_byte_o   = out_res.pl_byte;
  assign payload_index_o  = out_res.pl_index;
  assign frame_type_o     = out_res.ftype;
  assign payload_length_o = out_res.plen;
  assign status_o         = out_res.status;
  assign last_o           = out_res.last;

  // an end-of-buffer byte always yields a closing status result
  a_last_gives_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_last_q) |->
      ((push.n == 2'd1) && push.res0.last) || ((push.n == 2'd2) && push.res1.last))
    else $error("end of buffer without status result");

  // a byte that is not the last never yields a status result
  a_no_stray_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s1_last_q) |-> (push.n != 2'd2) && !push.res0.last)
    else $error("status result outside end of buffer");

  a_last_is_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (result_kind_o == hfd_pkg::KindStatus)))
    else $error("last flag and result kind disagree");

endmodule

// ===== verif/tb_hdlc_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_frame_deframer
// Self-checking bench for the HDLC deframer. A short directed set of buffers
// hits the escape corner cases and every outcome code, then randomly built
// buffers follow. Most are well-formed stuffed frames; the rest are
// short buffers and raw noise. A local model of the unstuffing and
// header logic predicts every payload and status result, and a monitor
// checks them in order. Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module tb_hdlc_frame_deframer;

  localparam int unsigned StimTarget  = 1875;  // directed plus random bytes
  localparam int unsigned QuietTail   = 250;   // no idling for the last bytes
  localparam int unsigned StallLimit  = 500;   // cycles without any transaction
  localparam int unsigned DrainCycles = 20;    // pipeline plus result queue
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [7:0] raw;
    logic       eob;  // last byte of the buffer
  } raw_item_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  raw_byte       = '0;
  logic        last_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] frame_type;
  logic [15:0] payload_length;
  logic [1:0]  status;
  logic        res_last;

  hdlc_frame_deframer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_byte_i       (raw_byte),
    .last_of_buffer_i (last_of_buffer),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind),
    .payload_byte_o   (payload_byte),
    .payload_index_o  (payload_index),
    .frame_type_o     (frame_type),
    .payload_length_o (payload_length),
    .status_o         (status),
    .last_o           (res_last)
  );

  // --------------------------------------------------------------------------
  // Deframer model: own copy of the unstuffing state and header registers.
  // Fed once per accepted input transaction, it appends the results that
  // byte causes to the expected-result queue.
  // --------------------------------------------------------------------------
  logic                          esc_mark;
  logic [hfd_pkg::RawCntW-1:0]   raw_seen;
  logic [hfd_pkg::UnsCntW-1:0]   unstuffed_seen;
  logic [15:0]                   hdr_type;
  logic [15:0]                   hdr_len;

  hfd_pkg::result_t expected_results[$];
  raw_item_t        raw_items[$];
  logic [7:0]       frame_bytes[$];  // buffer under construction

  int unsigned mismatch_count = 0;

  task automatic clear_deframe_state();
    esc_mark       = 1'b0;
    raw_seen       = '0;
    unstuffed_seen = '0;
    hdr_type       = '0;
    hdr_len        = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] raw, input logic eob);
    hfd_pkg::result_t r;
    logic [7:0]       data;
    logic             have_data;
    have_data = 1'b0;
    data      = '0;

    if (raw_seen < hfd_pkg::RawSat) raw_seen++;

    // flags vanish, even straight after an escape (the mark survives them);
    // a second escape keeps the mark set
    if (raw == hfd_pkg::FlagByte) begin
    end else if (raw == hfd_pkg::EscByte) begin
      esc_mark = 1'b1;
    end else begin
      data      = esc_mark ? (raw ^ hfd_pkg::EscXor) : raw;
      esc_mark  = 1'b0;
      have_data = 1'b1;
    end

    if (have_data) begin
      if (unstuffed_seen < hfd_pkg::HeaderBytes / 2) begin
        hdr_type = {hdr_type[7:0], data};
      end else if (unstuffed_seen < hfd_pkg::HeaderBytes) begin
        hdr_len = {hdr_len[7:0], data};
      end else if (unstuffed_seen - hfd_pkg::HeaderBytes < hdr_len) begin
        // payload goes out at once; surplus past the declared length is lost
        r          = '0;
        r.kind     = hfd_pkg::KindPayload;
        r.pl_byte  = data;
        r.pl_index = 16'(unstuffed_seen - hfd_pkg::HeaderBytes);
        r.status   = hfd_pkg::StComplete;
        expected_results = {expected_results, r};
      end
      if (unstuffed_seen != '1) unstuffed_seen++;
    end

    if (eob) begin
      r        = '0;
      r.kind   = hfd_pkg::KindStatus;
      r.last   = 1'b1;
      r.status = hfd_pkg::StComplete;
      // raw-count check outranks the header check, which outranks length
      if (raw_seen < hfd_pkg::RawSat) begin
        r.status = hfd_pkg::StRawShort;
      end else if (unstuffed_seen < hfd_pkg::HeaderBytes) begin
        r.status = hfd_pkg::StHeaderIncompl;
      end else begin
        r.ftype  = hdr_type;
        r.plen   = hdr_len;
        r.status = (unstuffed_seen - hfd_pkg::HeaderBytes >= hdr_len)
                   ? hfd_pkg::StComplete : hfd_pkg::StPayloadShort;
      end
      expected_results = {expected_results, r};
      clear_deframe_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // Buffer construction
  // --------------------------------------------------------------------------
  // content biased towards the two special bytes and their escaped forms
  function automatic logic [7:0] content_byte();
    logic [7:0] picks [4];
    picks = '{hfd_pkg::FlagByte, hfd_pkg::EscByte,
              hfd_pkg::FlagByte ^ hfd_pkg::EscXor, hfd_pkg::EscByte ^ hfd_pkg::EscXor};
    if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // byte stuffing as a sender would do it, with the odd stray flag
  task automatic put_stuffed(input logic [7:0] b);
    if (b == hfd_pkg::FlagByte || b == hfd_pkg::EscByte) begin
      frame_bytes = {frame_bytes, hfd_pkg::EscByte};
      if ($urandom_range(0, 19) == 0) frame_bytes = {frame_bytes, hfd_pkg::FlagByte};
      frame_bytes = {frame_bytes, b ^ hfd_pkg::EscXor};
    end else begin
      frame_bytes = {frame_bytes, b};
    end
    if ($urandom_range(0, 39) == 0) frame_bytes = {frame_bytes, hfd_pkg::FlagByte};
  endtask

  // move the buffer under construction to the stimulus, marking its end
  task automatic queue_buffer();
    raw_item_t it;
    foreach (frame_bytes[i]) begin
      it.raw = frame_bytes[i];
      it.eob = (i == frame_bytes.size() - 1);
      raw_items = {raw_items, it};
    end
    frame_bytes.delete();
  endtask

  task automatic build_random_buffer();
    int unsigned sel;
    int unsigned n_payload;
    logic [15:0] ftype;
    logic [15:0] plen;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      // well-formed frame with random content
      if ($urandom_range(0, 1) == 1) frame_bytes = {frame_bytes, hfd_pkg::FlagByte};
      ftype = 16'($urandom);
      if ($urandom_range(0, 29) == 0) plen = 16'($urandom_range(49, 65535));
      else if ($urandom_range(0, 9) == 0) plen = 16'($urandom_range(13, 48));
      else plen = 16'($urandom_range(0, 12));
      sel = $urandom_range(0, 19);
      if (plen > 48) n_payload = $urandom_range(0, 12);  // always short
      else if (sel < 14) n_payload = plen;
      else if (sel < 17 && plen != 0) n_payload = $urandom_range(0, plen - 1);
      else n_payload = plen + $urandom_range(1, 4);
      put_stuffed(ftype[15:8]);
      put_stuffed(ftype[7:0]);
      put_stuffed(plen[15:8]);
      put_stuffed(plen[7:0]);
      repeat (n_payload) put_stuffed(content_byte());
      if ($urandom_range(0, 1) == 1) frame_bytes = {frame_bytes, hfd_pkg::FlagByte};
    end else if (sel < 85) begin
      // short buffer, often a partial header
      repeat ($urandom_range(1, 7)) put_stuffed(content_byte());
    end else begin
      // unstuffed noise: broken escapes, flags anywhere
      repeat ($urandom_range(1, 20)) frame_bytes = {frame_bytes, content_byte()};
    end
    queue_buffer();
  endtask

  // --------------------------------------------------------------------------
  // Idle control. Burst rates are re-drawn each time rate_timer wraps, zero
  // included, so some stretches run flat out. Near the end neither side idles.
  // --------------------------------------------------------------------------
  logic [7:0]  rate_timer    = '0;
  int unsigned in_idle_rate  = 0;  // out of 16, per transaction slot
  int unsigned out_idle_rate = 0;

  always @(posedge clk) begin
    rate_timer <= rate_timer + 8'd1;
    if (rate_timer == '0) begin
      in_idle_rate  <= 2 * $urandom_range(0, 3);
      out_idle_rate <= 2 * $urandom_range(0, 3);
    end
  end

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;
  raw_item_t   next_item;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      raw_byte       <= '0;
      last_of_buffer <= 1'b0;
      in_gap = 0;
      clear_deframe_state();
    end else begin
      if (in_valid && in_ready) deframe_byte(raw_byte, last_of_buffer);

      // payload may only change once the current transaction is taken
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (raw_items.size() > QuietTail &&
                     $urandom_range(0, 15) < in_idle_rate) begin
          in_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (raw_items.size() != 0) begin
          next_item = raw_items.pop_front();
          in_valid       <= 1'b1;
          raw_byte       <= next_item.raw;
          last_of_buffer <= next_item.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and scoreboard
  // --------------------------------------------------------------------------
  int unsigned      out_gap = 0;
  hfd_pkg::result_t seen_res;
  hfd_pkg::result_t want_res;

  function automatic string fmt_result(input hfd_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h idx=%0d type=%04h len=%0d st=%0d last=%0d",
                     r.kind, r.pl_byte, r.pl_index, r.ftype, r.plen, r.status, r.last);
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_res.kind     = result_kind;
        seen_res.pl_byte  = payload_byte;
        seen_res.pl_index = payload_index;
        seen_res.ftype    = frame_type;
        seen_res.plen     = payload_length;
        seen_res.status   = hfd_pkg::status_e'(status);
        seen_res.last     = res_last;
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result: %s", fmt_result(seen_res)));
        end else begin
          want_res = expected_results.pop_front();
          if (seen_res !== want_res)
            report_error($sformatf("result mismatch\n  exp: %s\n  got: %s",
                                   fmt_result(want_res), fmt_result(seen_res)));
        end
      end

      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (raw_items.size() > QuietTail &&
                   $urandom_range(0, 15) < out_idle_rate) begin
        out_gap = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on either side restarts the count
  // --------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("hdlc_frame_deframer test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // escape after escape, flag inside an escape, escaped 0x7E; header
    // 7E00 / 0001, one payload byte, then an escaped flag as surplus
    frame_bytes = {8'h7D, 8'h7D, 8'h7E, 8'h5E, 8'h00, 8'h00, 8'h01, 8'h11,
                   8'h7D, 8'h5E};
    queue_buffer();
    // six raw bytes, nothing unstuffed, escape still open at the end
    frame_bytes = {8'h7E, 8'h7E, 8'h7D, 8'h7E, 8'h7E, 8'h7D};
    queue_buffer();
    // 5E must pass unchanged (escape was cleared); full header, but only
    // five raw bytes, so raw-short wins; payload byte and status together
    frame_bytes = {8'h5E, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    queue_buffer();
    // payload short with enough raw bytes, again two results on the last
    frame_bytes = {8'h7E, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
    queue_buffer();

    while (raw_items.size() < StimTarget) build_random_buffer();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (raw_items.size() == 0 && !in_valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0)
      $display("hdlc_frame_deframer test passed");
    else
      $display("hdlc_frame_deframer test failed");
    $finish;
  end

endmodule
